### rtl/range_outlier_filter_assert.svh
// Assertion macros shared by the range outlier filter modules.
`ifndef RANGE_OUTLIER_FILTER_ASSERT_SVH
`define RANGE_OUTLIER_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ROF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range outlier filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ROF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range outlier filter check failed");

`endif

### rtl/rof_pkg.sv
`timescale 1ns / 1ps

package rof_pkg;

  localparam int RANGE_W = 14;
  localparam int MIN_W   = 12;
  localparam int PCT_W   = 7;
  localparam int WIN_W   = 8;
  localparam int REJ_W   = 9;
  localparam int PROD_W  = RANGE_W + PCT_W;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [MIN_W-1:0]   MIN_RANGE_RST  = 12'd0;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 14'd10000;
  localparam logic [PCT_W-1:0]   CHANGE_PCT_RST = 7'd10;
  localparam logic [WIN_W-1:0]   LOST_WIN_RST   = 8'd10;
  localparam logic [WIN_W-1:0]   RESYNC_RST     = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE  = 3'd0,
    REG_MAX_RANGE  = 3'd1,
    REG_CHANGE_PCT = 3'd2,
    REG_LOST_WIN   = 3'd3,
    REG_RESYNC     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic               is_zero;
    logic               in_closed;
    logic               in_open;
  } item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic               accepted;
    logic               lost;
  } res_t;

endpackage

### rtl/rof_fifo.sv
`timescale 1ns / 1ps

module rof_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  `include "range_outlier_filter_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ROF_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ROF_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop,
                   count == $past(count) + CNT_W'(1))
  `ROF_ASSERT_NEXT(a_pop_shrinks, clk, rst, do_pop && !do_push,
                   count == $past(count) - CNT_W'(1))

endmodule

### rtl/rof_front.sv
`timescale 1ns / 1ps

module rof_front (
  input  logic [rof_pkg::BYTE_W-1:0]  range_low_byte,
  input  logic [rof_pkg::BYTE_W-1:0]  range_high_byte,
  input  logic [rof_pkg::MIN_W-1:0]   min_range_cm,
  input  logic [rof_pkg::RANGE_W-1:0] max_range_cm,
  output rof_pkg::item_t              item
);

  import rof_pkg::*;

  logic [RANGE_W-1:0] r;
  logic               nonzero;
  logic               below_max;
  logic               at_min;
  logic               above_min;

  assign r         = {range_high_byte[6:0], range_low_byte[6:0]};
  assign nonzero   = (r != '0);
  assign below_max = (r <= max_range_cm);
  assign at_min    = (r >= {2'b00, min_range_cm});
  assign above_min = (r > {2'b00, min_range_cm});

  assign item.range     = r;
  assign item.is_zero   = !nonzero;
  assign item.in_closed = nonzero && below_max && at_min;
  assign item.in_open   = nonzero && below_max && above_min;

endmodule

### rtl/rof_back.sv
`timescale 1ns / 1ps

module rof_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rof_pkg::PCT_W-1:0]   change_percent,
  input  logic [rof_pkg::WIN_W-1:0]   lost_window,
  input  logic [rof_pkg::WIN_W-1:0]   resync_limit,
  input  logic                        item_valid,
  input  rof_pkg::item_t              item,
  output logic                        item_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output rof_pkg::res_t               res
);

  import rof_pkg::*;

  `include "range_outlier_filter_assert.svh"

  logic [RANGE_W-1:0] ref_range;
  logic [RANGE_W-1:0] ref_range_next;
  logic               first_pending;
  logic               lost_flag;
  logic               lost_flag_next;
  logic [WIN_W-1:0]   zero_run;
  logic [WIN_W-1:0]   zero_run_next;
  logic [REJ_W-1:0]   reject_run;
  logic [REJ_W-1:0]   reject_run_next;

  logic               fire;
  logic [RANGE_W-1:0] ref_eff;
  logic [WIN_W-1:0]   zero_inc;
  logic               lost_eff;
  logic               r_greater;
  logic [RANGE_W-1:0] big;
  logic [RANGE_W-1:0] diff;
  logic [PROD_W-1:0]  diff_scaled;
  logic [PROD_W-1:0]  big_scaled;
  logic               jump_ok;
  logic               normal_acc;
  logic               recovery_acc;
  logic               accepted;
  logic [REJ_W-1:0]   reject_inc;
  logic [REJ_W-1:0]   resync_bound;
  logic               resync;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  assign ref_eff  = first_pending ? item.range : ref_range;
  assign zero_inc = (zero_run == '1) ? zero_run : zero_run + WIN_W'(1);
  assign lost_eff = lost_flag || (item.is_zero && (zero_inc >= lost_window));

  assign r_greater   = (item.range > ref_eff);
  assign big         = r_greater ? item.range : ref_eff;
  assign diff        = r_greater ? (item.range - ref_eff) : (ref_eff - item.range);
  assign diff_scaled = {{PCT_W{1'b0}}, diff} * {{RANGE_W{1'b0}}, PCT_SCALE};
  assign big_scaled  = {{RANGE_W{1'b0}}, change_percent} * {{PCT_W{1'b0}}, big};
  assign jump_ok     = (diff_scaled < big_scaled);

  assign normal_acc   = !lost_eff && jump_ok && item.in_open;
  assign recovery_acc = lost_eff && item.in_closed;
  assign accepted     = normal_acc || recovery_acc;

  assign reject_inc   = (reject_run == '1) ? reject_run : reject_run + REJ_W'(1);
  assign resync_bound = {1'b0, resync_limit} + REJ_W'(1);
  assign resync       = !accepted && (reject_inc > resync_bound) && item.in_closed;

  always_comb begin
    ref_range_next  = (accepted || resync) ? item.range : ref_eff;
    lost_flag_next  = recovery_acc ? 1'b0 : lost_eff;
    zero_run_next   = item.is_zero ? zero_inc : '0;
    reject_run_next = (accepted || resync) ? '0 : reject_inc;
  end

  assign res.range    = item.range;
  assign res.accepted = accepted;
  assign res.lost     = lost_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_range     <= '0;
      first_pending <= 1'b1;
      lost_flag     <= 1'b0;
      zero_run      <= '0;
      reject_run    <= '0;
    end else if (fire) begin
      ref_range     <= ref_range_next;
      first_pending <= 1'b0;
      lost_flag     <= lost_flag_next;
      zero_run      <= zero_run_next;
      reject_run    <= reject_run_next;
    end
  end

  `ROF_ASSERT_SAME(a_accept_not_lost, clk, rst, fire && res.accepted, !res.lost)
  `ROF_ASSERT_NEXT(a_accept_sets_ref, clk, rst, fire && res.accepted,
                   (ref_range == $past(item.range)) && (reject_run == '0))
  `ROF_ASSERT_NEXT(a_zero_item_counts, clk, rst, fire && item.is_zero,
                   zero_run != '0)

endmodule

### rtl/range_outlier_filter.sv
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// input    | push / full        | range_low_byte, range_high_byte
// result   | pop / empty        | range_cm, accepted, lost
// config   | cfg_valid / ready  | cfg_index, cfg_data
//
// One reading is taken per cycle while full is low; the back end's filter
// state loop is combinational up to its state registers, including both
// jump-test multiplies. A result reaches the result ports after its reading
// is registered in the item queue and its result in the result queue.
// Synchronous reset clears the queues and the filter state and loads the
// register defaults. A stalled result side fills the result queue and then
// the item queue before full rises; cfg_ready is always high.

module range_outlier_filter #(
  parameter int QUEUE_DEPTH = rof_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [rof_pkg::BYTE_W-1:0]     range_low_byte,
  input  logic [rof_pkg::BYTE_W-1:0]     range_high_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [rof_pkg::RANGE_W-1:0]    range_cm,
  output logic                           accepted,
  output logic                           lost,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rof_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rof_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rof_pkg::*;

  logic [MIN_W-1:0]   min_range_cm;
  logic [RANGE_W-1:0] max_range_cm;
  logic [PCT_W-1:0]   change_percent;
  logic [WIN_W-1:0]   lost_window;
  logic [WIN_W-1:0]   resync_limit;

  item_t front_item;
  item_t back_item;
  logic  mid_empty;
  logic  mid_pop;
  res_t  back_res;
  res_t  out_res;
  logic  res_push;
  logic  res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_cm   <= MIN_RANGE_RST;
      max_range_cm   <= MAX_RANGE_RST;
      change_percent <= CHANGE_PCT_RST;
      lost_window    <= LOST_WIN_RST;
      resync_limit   <= RESYNC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_RANGE:  min_range_cm   <= cfg_data[MIN_W-1:0];
        REG_MAX_RANGE:  max_range_cm   <= cfg_data[RANGE_W-1:0];
        REG_CHANGE_PCT: change_percent <= cfg_data[PCT_W-1:0];
        REG_LOST_WIN:   lost_window    <= cfg_data[WIN_W-1:0];
        REG_RESYNC:     resync_limit   <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rof_front u_front (
    .range_low_byte  (range_low_byte),
    .range_high_byte (range_high_byte),
    .min_range_cm    (min_range_cm),
    .max_range_cm    (max_range_cm),
    .item            (front_item)
  );

  rof_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (full),
    .pop   (mid_pop),
    .dout  (back_item),
    .empty (mid_empty)
  );

  rof_back u_back (
    .clk            (clk),
    .rst            (rst),
    .change_percent (change_percent),
    .lost_window    (lost_window),
    .resync_limit   (resync_limit),
    .item_valid     (!mid_empty),
    .item           (back_item),
    .item_pop       (mid_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (back_res)
  );

  rof_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign range_cm = out_res.range;
  assign accepted = out_res.accepted;
  assign lost     = out_res.lost;

endmodule

### sim/tb_range_outlier_filter.sv
`timescale 1ns / 1ps

module tb_range_outlier_filter;
  import rof_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [BYTE_W-1:0] range_low_byte = '0;
  logic [BYTE_W-1:0] range_high_byte = '0;
  logic empty;
  logic pop = 1'b0;
  logic [RANGE_W-1:0] range_cm;
  logic accepted;
  logic lost;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  range_outlier_filter dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .range_low_byte(range_low_byte),
    .range_high_byte(range_high_byte),
    .empty(empty),
    .pop(pop),
    .range_cm(range_cm),
    .accepted(accepted),
    .lost(lost),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [MIN_W-1:0]   lo_limit_cm = MIN_RANGE_RST;
  logic [RANGE_W-1:0] hi_limit_cm = MAX_RANGE_RST;
  logic [PCT_W-1:0]   jump_pct    = CHANGE_PCT_RST;
  logic [WIN_W-1:0]   lost_win    = LOST_WIN_RST;
  logic [WIN_W-1:0]   resync_lim  = RESYNC_RST;

  logic [RANGE_W-1:0] track_cm = '0;
  logic               seed_pending = 1'b1;
  logic               lost_state = 1'b0;
  logic [WIN_W-1:0]   zero_run_cnt = '0;
  logic [REJ_W-1:0]   reject_cnt = '0;

  res_t filter_results_due[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   walk_cm = 1000;
  int   rx_hold_cycles = 0;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;

  function automatic res_t filter_reading(input logic [7:0] lo, input logic [7:0] hi);
    logic [RANGE_W-1:0] r;
    logic [RANGE_W-1:0] big;
    logic [RANGE_W-1:0] diff;
    logic jump_ok;
    logic in_closed;
    res_t res;
    r = {hi[6:0], lo[6:0]};
    if (seed_pending) begin
      track_cm = r;
      seed_pending = 1'b0;
    end
    if (r == '0) begin
      if (zero_run_cnt != '1) zero_run_cnt = zero_run_cnt + 1'b1;
      if (zero_run_cnt >= lost_win) lost_state = 1'b1;
    end else begin
      zero_run_cnt = '0;
    end
    big = (r > track_cm) ? r : track_cm;
    diff = (r > track_cm) ? r - track_cm : track_cm - r;
    jump_ok = (int'(diff) * 100) < (int'(jump_pct) * int'(big));
    in_closed = (r != '0) && (r <= hi_limit_cm) && (r >= lo_limit_cm);
    res.accepted = 1'b0;
    if (!lost_state && jump_ok && r != '0 && r <= hi_limit_cm && r > lo_limit_cm) begin
      res.accepted = 1'b1;
      track_cm = r;
      reject_cnt = '0;
    end else if (lost_state && in_closed) begin
      res.accepted = 1'b1;
      track_cm = r;
      lost_state = 1'b0;
      reject_cnt = '0;
    end else begin
      if (reject_cnt != '1) reject_cnt = reject_cnt + 1'b1;
      if (int'(reject_cnt) > int'(resync_lim) + 1 && in_closed) begin
        track_cm = r;
        reject_cnt = '0;
      end
    end
    res.range = r;
    res.lost = lost_state;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (filter_results_due.size() == 0) begin
        report_mismatch("result with none outstanding, range", range_cm, 0);
      end else begin
        want = filter_results_due.pop_front();
        if (range_cm !== want.range) report_mismatch("range_cm", range_cm, want.range);
        if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
        if (lost !== want.lost) report_mismatch("lost", lost, want.lost);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : result_taker
    int gap;
    wait (!rst);
    forever begin
      if (rx_hold_cycles != 0) begin
        pop <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic send_bytes(input int lo, input int hi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    range_low_byte <= 8'(lo);
    range_high_byte <= 8'(hi);
    do @(posedge clk); while (full);
    filter_results_due.insert(filter_results_due.size(), filter_reading(8'(lo), 8'(hi)));
  endtask

  task automatic send_range(input int r);
    logic [RANGE_W-1:0] rv;
    int lo;
    int hi;
    rv = 14'(r);
    lo = ($urandom_range(0, 1) << 7) | int'(rv[6:0]);
    hi = ($urandom_range(0, 1) << 7) | int'(rv[13:7]);
    send_bytes(lo, hi);
  endtask

  task automatic send_walk_step();
    int span;
    int r;
    span = walk_cm * int'(jump_pct) / 100;
    if ($urandom_range(0, 1) == 1) r = walk_cm + $urandom_range(0, span);
    else r = walk_cm - $urandom_range(0, span);
    if (r < 1) r = 1;
    if (r > 16383) r = 16383;
    walk_cm = r;
    send_range(r);
  endtask

  task automatic put_reg(input reg_idx_t idx, input int value, input int width);
    int spare;
    spare = $urandom;
    spare = spare & ~((1 << width) - 1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(spare | value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input int min_v, input int max_v, input int pct_v,
                               input int win_v, input int rsy_v);
    put_reg(REG_MIN_RANGE, min_v, MIN_W);
    put_reg(REG_MAX_RANGE, max_v, RANGE_W);
    put_reg(REG_CHANGE_PCT, pct_v, PCT_W);
    put_reg(REG_LOST_WIN, win_v, WIN_W);
    put_reg(REG_RESYNC, rsy_v, WIN_W);
    cfg_valid <= 1'b0;
    lo_limit_cm = 12'(min_v);
    hi_limit_cm = 14'(max_v);
    jump_pct = 7'(pct_v);
    lost_win = 8'(win_v);
    resync_lim = 8'(rsy_v);
    walk_cm = (int'(lo_limit_cm) + int'(hi_limit_cm)) / 2 + 1;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (filter_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_random_settings();
    load_settings($urandom_range(0, 600), $urandom_range(3000, 16383),
                  $urandom_range(2, 40), $urandom_range(1, 12), $urandom_range(0, 10));
  endtask

  task automatic test_default_settings();
    send_bytes(8'h80, 8'h80);
    send_bytes(8'h64, 8'h00);
    send_bytes(8'hE5, 8'h80);
    send_bytes(8'h66, 8'h00);
    send_bytes(8'h67, 8'h00);
    send_bytes(8'h68, 8'h00);
    send_bytes(8'h69, 8'h00);
    send_bytes(8'h6A, 8'h00);
    send_bytes(8'h7F, 8'h7F);
    send_bytes(8'h10, 8'h4E);
    send_bytes(8'hFF, 8'hFF);
  endtask

  task automatic test_special_cases();
    settle();
    load_settings(0, 16383, 127, 0, 0);
    send_range(5000);
    send_range(16383);
    send_range(0);
    send_range(16383);
    settle();
    load_settings(2500, 1000, 50, 1, 0);
    send_range(2000);
    send_range(500);
    send_range(3000);
    send_range(1000);
    settle();
    load_settings(100, 200, 50, 3, 1);
    send_range(150);
    send_range(100);
    send_range(200);
    repeat (3) send_range(0);
    send_range(100);
  endtask

  task automatic test_backpressure();
    settle();
    load_settings(0, 10000, 20, 4, 3);
    walk_cm = 3000;
    tx_idle = 1'b0;
    rx_hold_cycles = 90;
    repeat (24) send_walk_step();
    tx_idle = 1'b1;
  endtask

  task automatic test_tracking();
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: load_settings(0, 16383, 100, 1, 0);
        1: load_settings(2500, 2500, 10, 10, 5);
        4: load_settings(2500, 16383, 1, 255, 255);
        default: load_random_settings();
      endcase
      tx_idle = (phase != 2);
      rx_idle = (phase != 2) && (phase != 3);
      repeat (30) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_range($urandom_range(0, 16383));
        else if (pick == 1) send_range(0);
        else send_walk_step();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_lost_recovery();
    int sent;
    int run;
    int pick;
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      load_settings($urandom_range(0, 600), $urandom_range(3000, 16383),
                    $urandom_range(2, 60), $urandom_range(1, 6), $urandom_range(0, 8));
      sent = 0;
      while (sent < 30) begin
        run = $urandom_range(1, int'(lost_win) + 2);
        repeat (run) send_range(0);
        sent += run;
        run = $urandom_range(1, 3);
        repeat (run) begin
          pick = $urandom_range(0, 5);
          if (pick == 0) send_range(lo_limit_cm);
          else if (pick == 1) send_range(hi_limit_cm);
          else if (pick == 2) send_range($urandom_range(0, 16383));
          else send_walk_step();
        end
        sent += run;
      end
    end
  endtask

  task automatic test_counter_saturation();
    settle();
    load_settings(0, 12000, 10, 255, 255);
    repeat (300) send_range(0);
    repeat (220) send_range($urandom_range(12001, 16383));
    walk_cm = 5000;
    repeat (5) send_walk_step();
  endtask

  task automatic test_raw_bytes();
    settle();
    load_random_settings();
    repeat (60) send_bytes($urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_settings();
    test_special_cases();
    test_backpressure();
    test_tracking();
    test_lost_recovery();
    test_counter_saturation();
    test_raw_bytes();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && filter_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rof_pkg.sv
rtl/rof_fifo.sv
rtl/rof_front.sv
rtl/rof_back.sv
rtl/range_outlier_filter.sv
sim/tb_range_outlier_filter.sv
